>>> hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define LVN_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define LVN_ASSERT_NEXT(name, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

>>> hw/rtl/lvn_pkg.sv
// shared constants and types of the vector normaliser
`default_nettype none
package lvn_pkg;
	localparam int MAX_DIM_DEF   = 64;
	localparam int ELEM_BITS_DEF = 16;
	localparam int CFG_W         = 7;
	localparam logic [CFG_W-1:0] LEN_RESET = 7'd32;
	localparam int VNUM_W        = 16;
	localparam int OUT_W         = 16;
	// quotient of 2^32 * mag^2 / sum, at most 2^32
	localparam int QW            = 33;
	localparam int RADW          = 34;
	localparam int ROOTW         = 17;
	localparam int SRW           = 20;
	localparam int STEP_W        = 6;
	localparam logic [ROOTW-1:0] POS_LIMIT = 17'd32767;
	localparam logic [ROOTW-1:0] NEG_LIMIT = 17'd32768;
	localparam logic [ROOTW-1:0] WRAP_16   = 17'h10000;

	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;
endpackage
`default_nettype wire

>>> hw/rtl/lvn_store.sv
// double-banked element memory with registered read
`default_nettype none
module lvn_store #(
	parameter int MAX_DIM   = lvn_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = lvn_pkg::ELEM_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] wr_addr,
	input  wire logic [ELEM_BITS-1:0]                  wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] rd_addr,
	output logic      [ELEM_BITS-1:0]                  rd_data
);
	localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = 2 ** (AW + 1);

	logic [ELEM_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lvn_queue.sv
// two-entry job queue between front and back
`default_nettype none
module lvn_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	input  wire logic         pop,
	output logic      [W-1:0] dout,
	output logic              empty,
	output logic              full,
	output logic      [1:0]   level
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      level_q <= level_q + 2'd1;
			else if (pop && !push) level_q <= level_q - 2'd1;
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (level_q == 2'd0);
	assign full  = (level_q == 2'd2);
	assign level = level_q;
endmodule
`default_nettype wire

>>> hw/rtl/lvn_front.sv
// front end: takes elements, stores them, sums squares, posts jobs
`default_nettype none
module lvn_front #(
	parameter int MAX_DIM   = lvn_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = lvn_pkg::ELEM_BITS_DEF,
	parameter int CW        = $clog2(MAX_DIM + 1),
	parameter int SW        = 2 * ELEM_BITS - 1 + $clog2(MAX_DIM),
	parameter int JW        = SW + CW + 1 + lvn_pkg::VNUM_W + 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [lvn_pkg::CFG_W-1:0]             vector_length,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [15:0]                           element_value,
	output logic                                       wr_en,
	output logic      [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] wr_addr,
	output logic      [ELEM_BITS-1:0]                  wr_data,
	output logic                                       push,
	output logic      [JW-1:0]                         job,
	input  wire lvn_pkg::rel_t                         rel,
	output logic      [1:0]                            bank_busy
);
	localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int MAG2W = 2 * ELEM_BITS - 1;

	logic [CW-1:0]                 cnt_q;
	logic [SW-1:0]                 sum_q;
	logic                          bank_q;
	logic [lvn_pkg::VNUM_W-1:0]    vnum_q;
	logic [1:0]                    busy_q;

	logic [CW-1:0]          eff;
	logic [31:0]            raw32;
	logic [ELEM_BITS-1:0]   elem;
	logic [ELEM_BITS-1:0]   mag;
	logic [2*ELEM_BITS-1:0] mag2;
	logic [SW-1:0]          sum_next;
	logic [CW-1:0]          cnt_next;
	logic                   acc;
	logic                   last;
	logic [AW:0]            cnt_ext;
	logic [1:0]             busy_next;

	always_comb begin
		if (vector_length == '0) begin
			eff = CW'(1);
		end else if (vector_length > lvn_pkg::CFG_W'(MAX_DIM)) begin
			eff = CW'(MAX_DIM);
		end else begin
			eff = vector_length[CW-1:0];
		end
	end

	assign raw32    = {16'b0, element_value};
	assign elem     = raw32[ELEM_BITS-1:0];
	assign mag      = elem[ELEM_BITS-1] ? (~elem + 1'b1) : elem;
	assign mag2     = mag * mag;
	assign sum_next = sum_q + SW'(mag2[MAG2W-1:0]);
	assign cnt_next = cnt_q + 1'b1;
	assign in_stall = busy_q[bank_q];
	assign acc      = in_valid && !in_stall;
	assign last     = (cnt_next >= eff);
	assign cnt_ext  = (AW + 1)'(cnt_q);

	assign wr_en   = acc;
	assign wr_addr = {bank_q, cnt_ext[AW-1:0]};
	assign wr_data = elem;
	assign push    = acc && last;
	assign job     = {sum_next, cnt_next, bank_q, vnum_q, (sum_next != '0)};
	assign bank_busy = busy_q;

	// released bank and newly filled bank are never the same one
	always_comb begin
		busy_next = busy_q;
		if (rel.en) busy_next[rel.bank] = 1'b0;
		if (acc && last) busy_next[bank_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			bank_q <= 1'b0;
			vnum_q <= '0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_next;
			if (acc) begin
				if (last) begin
					cnt_q  <= '0;
					sum_q  <= '0;
					bank_q <= ~bank_q;
					vnum_q <= vnum_q + 1'b1;
				end else begin
					cnt_q <= cnt_next;
					sum_q <= sum_next;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lvn_back.sv
// back end: per element divide and square root, result register
`default_nettype none
module lvn_back #(
	parameter int MAX_DIM   = lvn_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = lvn_pkg::ELEM_BITS_DEF,
	parameter int CW        = $clog2(MAX_DIM + 1),
	parameter int SW        = 2 * ELEM_BITS - 1 + $clog2(MAX_DIM),
	parameter int JW        = SW + CW + 1 + lvn_pkg::VNUM_W + 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  q_empty,
	input  wire logic [JW-1:0]                         q_data,
	output logic                                       q_pop,
	output logic                                       rd_en,
	output logic      [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] rd_addr,
	input  wire logic [ELEM_BITS-1:0]                  rd_data,
	output lvn_pkg::rel_t                              rel,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [lvn_pkg::OUT_W-1:0]             normalized_value,
	output logic                                       vector_nonzero,
	output logic      [lvn_pkg::VNUM_W-1:0]            vector_number,
	output logic                                       last_of_vector
);
	localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int MAG2W = 2 * ELEM_BITS - 1;
	localparam int QW    = lvn_pkg::QW;
	localparam int RADW  = lvn_pkg::RADW;
	localparam int ROOTW = lvn_pkg::ROOTW;
	localparam int SRW   = lvn_pkg::SRW;
	localparam int STW   = lvn_pkg::STEP_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]                 state_q;
	logic [SW-1:0]              sum_q;
	logic [CW-1:0]              n_q;
	logic                       bank_q;
	logic [lvn_pkg::VNUM_W-1:0] vnum_q;
	logic                       nz_q;
	logic [CW-1:0]              k_q;
	logic [ELEM_BITS-1:0]       x_q;
	logic [MAG2W-1:0]           mag2_q;
	logic [SW-1:0]              rem_q;
	logic [QW-1:0]              quo_q;
	logic [STW-1:0]             step_q;
	logic [RADW-1:0]            rad_q;
	logic [SRW-1:0]             srem_q;
	logic [ROOTW-1:0]           root_q;
	logic                       ov_q;

	logic [ELEM_BITS-1:0]   mag;
	logic [2*ELEM_BITS-1:0] mag2;
	logic                   div_bit;
	logic [SW:0]            div_sh;
	logic                   div_ge;
	logic [QW-1:0]          quo_next;
	logic [SRW-1:0]         sq_sh;
	logic [SRW-1:0]         sq_trial;
	logic                   sq_ge;
	logic [ROOTW:0]         root_inc;
	logic [ROOTW-1:0]       m;
	logic [ROOTW-1:0]       m_neg;
	logic [ROOTW-1:0]       neg_val;
	logic [31:0]            x_ext;
	logic [lvn_pkg::OUT_W-1:0] res;
	logic                   out_free;
	logic                   is_last;
	logic [AW:0]            k_ext;
	logic                   ov_next;

	assign mag  = rd_data[ELEM_BITS-1] ? (~rd_data + 1'b1) : rd_data;
	assign mag2 = mag * mag;

	// restoring division, one quotient bit per cycle
	assign div_bit  = (step_q == STW'(QW - 1)) ? mag2_q[0] : 1'b0;
	assign div_sh   = {rem_q, div_bit};
	assign div_ge   = (div_sh >= {1'b0, sum_q});
	assign quo_next = {quo_q[QW-2:0], div_ge};

	// digit-by-digit square root, two radicand bits per cycle
	assign sq_sh    = {srem_q[SRW-3:0], rad_q[RADW-1 -: 2]};
	assign sq_trial = SRW'({root_q, 2'b01});
	assign sq_ge    = (sq_sh >= sq_trial);

	// round half away: largest m with 2m-1 <= isqrt(q)
	assign root_inc = {1'b0, root_q} + 1'b1;
	assign m        = root_inc[ROOTW:1];
	assign m_neg    = (m > lvn_pkg::NEG_LIMIT) ? lvn_pkg::NEG_LIMIT : m;
	assign neg_val  = lvn_pkg::WRAP_16 - m_neg;
	assign x_ext    = {{(32 - ELEM_BITS){x_q[ELEM_BITS-1]}}, x_q};

	always_comb begin
		if (!nz_q) begin
			res = x_ext[lvn_pkg::OUT_W-1:0];
		end else if (x_q[ELEM_BITS-1]) begin
			res = neg_val[lvn_pkg::OUT_W-1:0];
		end else if (m > lvn_pkg::POS_LIMIT) begin
			res = lvn_pkg::POS_LIMIT[lvn_pkg::OUT_W-1:0];
		end else begin
			res = m[lvn_pkg::OUT_W-1:0];
		end
	end

	assign out_free = !ov_q || !out_stall;
	assign is_last  = (k_q + 1'b1 == n_q);
	assign k_ext    = (AW + 1)'(k_q);
	assign ov_next  = ((state_q == ST_EMIT) && out_free) || (ov_q && out_stall);

	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = {bank_q, k_ext[AW-1:0]};
	assign rel.en   = (state_q == ST_EMIT) && out_free && is_last;
	assign rel.bank = bank_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= ov_next;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= nz_q ? ST_INIT : ST_EMIT;
				end
				ST_INIT: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (step_q == '0) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= is_last ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					{sum_q, n_q, bank_q, vnum_q, nz_q} <= q_data;
					k_q <= '0;
				end
			end
			ST_LOAD: begin
				x_q    <= rd_data;
				mag2_q <= mag2[MAG2W-1:0];
			end
			ST_INIT: begin
				rem_q  <= {{(SW - MAG2W + 1){1'b0}}, mag2_q[MAG2W-1:1]};
				quo_q  <= '0;
				step_q <= STW'(QW - 1);
			end
			ST_DIV: begin
				rem_q  <= div_ge ? SW'(div_sh - {1'b0, sum_q}) : div_sh[SW-1:0];
				quo_q  <= quo_next;
				if (step_q == '0) begin
					rad_q  <= RADW'(quo_next);
					srem_q <= '0;
					root_q <= '0;
					step_q <= STW'(ROOTW - 1);
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
			ST_SQRT: begin
				srem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
				root_q <= {root_q[ROOTW-2:0], sq_ge};
				rad_q  <= {rad_q[RADW-3:0], 2'b00};
				step_q <= step_q - 1'b1;
			end
			ST_EMIT: begin
				if (out_free) begin
					normalized_value <= res;
					vector_nonzero   <= nz_q;
					vector_number    <= vnum_q;
					last_of_vector   <= is_last;
					k_q              <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/l2_vector_normalizer.sv
// the last beat of a vector queues its job; the back end reads, divides, roots and emits
// each result of a nonzero vector takes a 33-step divide and a 17-step root, one at a time
// an all-zero vector skips both; input takes 1 beat per cycle unless stalled
// input stalls only while both element banks hold vectors not yet fully emitted
// reset: asynchronous active low, clears counts, sums, queue, bank flags, length to 32
`default_nettype none
`include "assert_macros.svh"
module l2_vector_normalizer #(
	parameter int MAX_DIM   = lvn_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = lvn_pkg::ELEM_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lvn_pkg::CFG_W-1:0]    vector_length,
	// element input
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [15:0]                  element_value,
	// result output
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [lvn_pkg::OUT_W-1:0]    normalized_value,
	output logic                              vector_nonzero,
	output logic      [lvn_pkg::VNUM_W-1:0]   vector_number,
	output logic                              last_of_vector
);
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW = $clog2(MAX_DIM + 1);
	// sum of squares width: max element square times max length
	localparam int SW = 2 * ELEM_BITS - 1 + $clog2(MAX_DIM);
	localparam int JW = SW + CW + 1 + lvn_pkg::VNUM_W + 1;

	logic [lvn_pkg::CFG_W-1:0] len_q;

	// element memory traffic
	logic                 wr_en;
	logic [AW:0]          wr_addr;
	logic [ELEM_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [AW:0]          rd_addr;
	logic [ELEM_BITS-1:0] rd_data;

	// job queue
	logic          push;
	logic [JW-1:0] job_in;
	logic          pop;
	logic [JW-1:0] job_out;
	logic          q_empty;
	logic          q_full;
	logic [1:0]    q_level;

	lvn_pkg::rel_t rel;
	logic [1:0]    bank_busy;

	// register is always writable; config only changes while idle is up to the user, not enforced
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= lvn_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= vector_length;
		end
	end

	// front: one element per beat into the free bank
	lvn_front #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS),
		.CW        (CW),
		.SW        (SW),
		.JW        (JW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.vector_length (len_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.push          (push),
		.job           (job_in),
		.rel           (rel),
		.bank_busy     (bank_busy)
	);

	// two banks, so one vector fills while the other drains
	lvn_store #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// finished vectors waiting for the back end
	lvn_queue #(
		.W (JW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.empty  (q_empty),
		.full   (q_full),
		.level  (q_level)
	);

	// back: divide and root per element, holds one result beat
	lvn_back #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS),
		.CW        (CW),
		.SW        (SW),
		.JW        (JW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_data           (job_out),
		.q_pop            (pop),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data),
		.rel              (rel),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.normalized_value (normalized_value),
		.vector_nonzero   (vector_nonzero),
		.vector_number    (vector_number),
		.last_of_vector   (last_of_vector)
	);

	// a queued or draining vector always holds its bank
	`LVN_ASSERT(a_push_not_full, !(push && q_full), "job pushed into a full queue")
	`LVN_ASSERT(a_pop_not_empty, !(pop && q_empty), "job popped from an empty queue")
	`LVN_ASSERT(a_banks_cover_queue, $countones(bank_busy) >= q_level,
		"queued jobs exceed busy banks")
	`LVN_ASSERT_NEXT(a_release_frees, rel.en && !push, !bank_busy[$past(rel.bank)],
		"released bank still busy")
endmodule
`default_nettype wire
